FILE: src/npc_pkg.sv
// Shared types and constants for the nearest palette color search.
package npc_pkg;

    // Palette geometry and field widths.
    localparam int PALETTE_SIZE = 216;
    localparam int IDX_W        = 8;
    localparam int COLOR_W      = 8;
    localparam int SQ_W         = 2 * COLOR_W;
    localparam int DIST_W       = 18;

    // Largest distance a real palette entry can produce, and the starting
    // best distance, which lies above it so that entry zero always wins.
    localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(195075);
    localparam logic [DIST_W-1:0] DIST_INIT = {DIST_W{1'b1}};

    // Request kinds.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // One request as it travels down the row of cells, with the best match so far.
    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [IDX_W-1:0]   best_idx;
        logic [DIST_W-1:0]  best_dist;
    } item_t;

endpackage

FILE: src/npc_cell.sv
// One palette cell: holds one entry, scores passing queries against it.
module npc_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic [npc_pkg::IDX_W-1:0] cell_idx,
    input  npc_pkg::item_t            item_in,
    output npc_pkg::item_t            item_out
);

    logic [npc_pkg::COLOR_W-1:0] blue_reg, green_reg, red_reg;
    logic [npc_pkg::COLOR_W-1:0] d_blue, d_green, d_red;
    logic [npc_pkg::SQ_W-1:0]    sq_blue_reg, sq_green_reg, sq_red_reg;
    logic [npc_pkg::SQ_W-1:0]    sq_blue_next, sq_green_next, sq_red_next;
    logic [npc_pkg::DIST_W-1:0]  dist_sum;
    logic                        load_hit;
    npc_pkg::item_t              s1_reg, s1_next;
    npc_pkg::item_t              out_reg, out_next;

    // A load request whose index names this cell replaces the stored color.
    assign load_hit = item_in.valid && (item_in.req_type == npc_pkg::REQ_LOAD)
                      && (item_in.entry_index == cell_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blue_reg  <= '0;
            green_reg <= '0;
            red_reg   <= '0;
        end else if (en && load_hit) begin
            blue_reg  <= item_in.blue;
            green_reg <= item_in.green;
            red_reg   <= item_in.red;
        end
    end

    // First stage: absolute channel differences and their squares.
    always_comb begin
        d_blue  = (item_in.blue  > blue_reg)  ? item_in.blue  - blue_reg  : blue_reg  - item_in.blue;
        d_green = (item_in.green > green_reg) ? item_in.green - green_reg : green_reg - item_in.green;
        d_red   = (item_in.red   > red_reg)   ? item_in.red   - red_reg   : red_reg   - item_in.red;
        sq_blue_next  = npc_pkg::SQ_W'(d_blue)  * npc_pkg::SQ_W'(d_blue);
        sq_green_next = npc_pkg::SQ_W'(d_green) * npc_pkg::SQ_W'(d_green);
        sq_red_next   = npc_pkg::SQ_W'(d_red)   * npc_pkg::SQ_W'(d_red);
        s1_next       = item_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
        end else if (en) begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_blue_reg  <= sq_blue_next;
            sq_green_reg <= sq_green_next;
            sq_red_reg   <= sq_red_next;
        end
    end

    // Second stage: total distance, and a strict compare so lower indexes keep ties.
    always_comb begin
        dist_sum = npc_pkg::DIST_W'(sq_blue_reg) + npc_pkg::DIST_W'(sq_green_reg)
                   + npc_pkg::DIST_W'(sq_red_reg);
        out_next = s1_reg;
        if (s1_reg.req_type == npc_pkg::REQ_QUERY && dist_sum < s1_reg.best_dist) begin
            out_next.best_dist = dist_sum;
            out_next.best_idx  = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg <= out_next;
        end
    end

    assign item_out = out_reg;

    // A query leaving the cell never carries a worse distance than it came with.
    a_best_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && s1_reg.valid && s1_reg.req_type == npc_pkg::REQ_QUERY)
        |=> (out_reg.best_dist <= $past(s1_reg.best_dist)))
        else $error("cell best distance grew");

    // A load addressed to this cell leaves exactly its color in the cell.
    a_load_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && load_hit)
        |=> (blue_reg == $past(item_in.blue) && green_reg == $past(item_in.green)
             && red_reg == $past(item_in.red)))
        else $error("cell load not stored");

endmodule

FILE: src/nearest_palette_color.sv
// Top level: nearest palette color search over a row of palette cells.
//
// Requests arrive on the s_ channel (valid/ready). A load request
// (s_req_type = 0) writes one palette entry and returns nothing; indexes at
// or beyond the palette size match no cell and are dropped. A query request
// (s_req_type = 1) returns, on the m_ channel, the index of the closest
// palette entry by squared RGB distance and that distance; the lowest index
// wins a tie.
// Every request walks the row of palette cells, two register stages per
// cell, then passes an output register before a query's result appears
// on the m_ channel.
// One request is accepted per cycle while the output side keeps up; loads
// and queries keep their order, so a query sees every earlier load.
// When the receiver holds m_ready low with a result waiting, the whole
// row freezes and s_ready drops until the result is taken.
// Reset clears every palette entry to black and empties the row.
module nearest_palette_color (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [npc_pkg::IDX_W-1:0]     s_entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]   s_color_blue,
    input  logic [npc_pkg::COLOR_W-1:0]   s_color_green,
    input  logic [npc_pkg::COLOR_W-1:0]   s_color_red,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [npc_pkg::IDX_W-1:0]     m_nearest_index,
    output logic [npc_pkg::DIST_W-1:0]    m_nearest_distance
);

    logic                       en;
    logic                       m_valid_reg, m_valid_next;
    logic [npc_pkg::IDX_W-1:0]  m_index_reg;
    logic [npc_pkg::DIST_W-1:0] m_dist_reg;
    npc_pkg::item_t             chain [npc_pkg::PALETTE_SIZE+1];

    // The row advances whenever the output register is free or being emptied.
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Request entering the first cell.
    always_comb begin
        chain[0].valid       = s_valid;
        chain[0].req_type    = s_req_type;
        chain[0].entry_index = s_entry_index;
        chain[0].blue        = s_color_blue;
        chain[0].green       = s_color_green;
        chain[0].red         = s_color_red;
        chain[0].best_idx    = '0;
        chain[0].best_dist   = npc_pkg::DIST_INIT;
    end

    // Row of palette cells, each knowing its own index.
    for (genvar i = 0; i < npc_pkg::PALETTE_SIZE; i++) begin : g_cell
        npc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_idx (npc_pkg::IDX_W'(i)),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    // Output register: only queries produce a result.
    assign m_valid_next = chain[npc_pkg::PALETTE_SIZE].valid
                          && (chain[npc_pkg::PALETTE_SIZE].req_type == npc_pkg::REQ_QUERY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_index_reg <= chain[npc_pkg::PALETTE_SIZE].best_idx;
            m_dist_reg  <= chain[npc_pkg::PALETTE_SIZE].best_dist;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_nearest_index    = m_index_reg;
    assign m_nearest_distance = m_dist_reg;

    // Every result comes from a real entry, so its distance is in range.
    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_dist_reg <= npc_pkg::DIST_MAX))
        else $error("result distance out of range");

    // Every result names an entry inside the palette.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ({1'b0, m_index_reg} < (npc_pkg::IDX_W+1)'(npc_pkg::PALETTE_SIZE)))
        else $error("result index out of range");

endmodule
